@@ hw/rtl/sgc_pkg.sv @@
// Shared types, constants and glyph tables for the scaled glyph cell generator.
package sgc_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int GLYPH_BITS     = 15;
  localparam int ADVANCE_GAP    = 4;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int SCALE_BITS     = 8;
  localparam int COLOUR_BITS    = 8;
  localparam int CELL_IDX_BITS  = 4;

  typedef logic [GLYPH_BITS-1:0]    glyph_t;
  typedef logic [CELL_IDX_BITS-1:0] cell_idx_t;

  // Register indexes of the configuration port
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_CELL_SCALE = 3'd2,
    REG_COLOR_R    = 3'd3,
    REG_COLOR_G    = 3'd4,
    REG_COLOR_B    = 3'd5,
    REG_CLEAR_BG   = 3'd6
  } cfg_reg_t;

  // Character codes
  localparam logic [7:0] CODE_LF    = 8'h0A;
  localparam logic [7:0] CODE_CR    = 8'h0D;
  localparam logic [7:0] CODE_SPACE = 8'h20;
  localparam logic [7:0] CODE_BANG  = 8'h21;
  localparam logic [7:0] CODE_PLUS  = 8'h2B;
  localparam logic [7:0] CODE_MINUS = 8'h2D;
  localparam logic [7:0] CODE_DOT   = 8'h2E;
  localparam logic [7:0] CODE_ZERO  = 8'h30;
  localparam logic [7:0] CODE_NINE  = 8'h39;
  localparam logic [7:0] CODE_COLON = 8'h3A;
  localparam logic [7:0] CODE_EQUAL = 8'h3D;
  localparam logic [7:0] CODE_A     = 8'h41;
  localparam logic [7:0] CODE_Z     = 8'h5A;

  localparam glyph_t BOX_GLYPH   = 15'h7B6F;
  localparam glyph_t GLYPH_BLANK = 15'h0000;
  localparam glyph_t GLYPH_MINUS = 15'h01C0;
  localparam glyph_t GLYPH_PLUS  = 15'h05D0;
  localparam glyph_t GLYPH_COLON = 15'h0410;
  localparam glyph_t GLYPH_EQUAL = 15'h0E38;
  localparam glyph_t GLYPH_DOT   = 15'h2000;
  localparam glyph_t GLYPH_BANG  = 15'h2092;

  localparam glyph_t DIGIT_ROM [10] = '{
    15'h7B6F, 15'h4926, 15'h73E7, 15'h79A7, 15'h49ED,
    15'h79CF, 15'h7BCF, 15'h4927, 15'h7BEF, 15'h79EF
  };

  localparam glyph_t LETTER_ROM [26] = '{
    15'h5BEF, 15'h7AEF, 15'h724F, 15'h3B6B, 15'h72CF, 15'h12CF, 15'h7B4F, 15'h5BED,
    15'h7497, 15'h7B26, 15'h5AED, 15'h7249, 15'h5B7D, 15'h5B6F, 15'h7B6F, 15'h13EF,
    15'h4F6F, 15'h5AEF, 15'h79CF, 15'h2497, 15'h7B6D, 15'h176D, 15'h5F6D, 15'h5AAD,
    15'h24AD, 15'h72A7
  };

  // Column and row of each glyph bit; the sixteenth entry is padding
  localparam logic [1:0] CELL_COL [16] = '{
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
    2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0
  };
  localparam logic [2:0] CELL_ROW [16] = '{
    3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2,
    3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd0
  };

  // Lit bits and bits to be drawn (lit, or all of them when clearing)
  typedef struct packed {
    glyph_t lit;
    glyph_t emit;
  } sgc_cells_t;

  typedef struct packed {
    logic [COLOUR_BITS-1:0] red;
    logic [COLOUR_BITS-1:0] green;
    logic [COLOUR_BITS-1:0] blue;
  } sgc_colour_t;

  function automatic glyph_t glyph_for(input logic [7:0] code);
    logic [7:0] off;
    glyph_t     g;
    off = '0;
    if (code inside {[CODE_ZERO:CODE_NINE]}) begin
      off = code - CODE_ZERO;
      g   = DIGIT_ROM[off[3:0]];
    end else if (code inside {[CODE_A:CODE_Z]}) begin
      off = code - CODE_A;
      g   = LETTER_ROM[off[4:0]];
    end else begin
      case (code)
        CODE_SPACE: g = GLYPH_BLANK;
        CODE_MINUS: g = GLYPH_MINUS;
        CODE_PLUS:  g = GLYPH_PLUS;
        CODE_COLON: g = GLYPH_COLON;
        CODE_EQUAL: g = GLYPH_EQUAL;
        CODE_DOT:   g = GLYPH_DOT;
        CODE_BANG:  g = GLYPH_BANG;
        default:    g = BOX_GLYPH;
      endcase
    end
    return g;
  endfunction

endpackage

@@ hw/rtl/sgc_front.sv @@
// Front end: takes character requests, moves the cursor, queues glyphs to draw.
module sgc_front #(
  parameter int COORD_BITS = sgc_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_char_code,
  input  logic                             in_first_char,
  input  logic [COORD_BITS-1:0]            origin_x,
  input  logic [COORD_BITS-1:0]            origin_y,
  input  logic [sgc_pkg::SCALE_BITS-1:0]   cell_scale,
  input  logic                             clear_background,
  output logic                             push_valid,
  input  logic                             push_ready,
  output logic [COORD_BITS-1:0]            push_x,
  output logic [COORD_BITS-1:0]            push_y,
  output sgc_pkg::sgc_cells_t              push_cells
);
  import sgc_pkg::*;

  logic [COORD_BITS-1:0] col_r, col_nxt;
  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic [COORD_BITS-1:0] col_base, row_base;
  logic [COORD_BITS-1:0] lf_step, adv_step;
  logic [10:0]           scale_p1, lf_w;
  logic [9:0]            adv_w;
  logic [31:0]           lf_ext, adv_ext;
  logic                  accept, is_cr, is_lf;
  glyph_t                lit;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  assign is_cr = (in_char_code == CODE_CR);
  assign is_lf = (in_char_code == CODE_LF);

  assign col_base = in_first_char ? '0 : col_r;
  assign row_base = in_first_char ? '0 : row_r;

  // 5*(scale+1) and 3*scale+4 by shift and add
  assign scale_p1 = {3'd0, cell_scale} + 11'd1;
  assign lf_w     = (scale_p1 << 2) + scale_p1;
  assign adv_w    = ({2'd0, cell_scale} << 1) + {2'd0, cell_scale} + 10'(ADVANCE_GAP);
  assign lf_ext   = 32'(lf_w);
  assign adv_ext  = 32'(adv_w);
  assign lf_step  = lf_ext[COORD_BITS-1:0];
  assign adv_step = adv_ext[COORD_BITS-1:0];

  assign lit             = glyph_for(in_char_code);
  assign push_cells.lit  = lit;
  assign push_cells.emit = lit | {GLYPH_BITS{clear_background}};
  assign push_x          = origin_x + col_base;
  assign push_y          = origin_y + row_base;
  assign push_valid      = accept && !is_cr && !is_lf && (cell_scale != '0)
                           && (push_cells.emit != '0);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (is_cr) begin
        col_nxt = '0;
        row_nxt = row_base;
      end else if (is_lf) begin
        col_nxt = col_base;
        row_nxt = row_base + lf_step;
      end else begin
        col_nxt = col_base + adv_step;
        row_nxt = row_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

@@ hw/rtl/sgc_queue.sv @@
// Small register queue between the front and back ends.
module sgc_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = sgc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import sgc_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                push, pop;

  assign push_ready = (count_r < CNT_BITS'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count missed a push");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count missed a pop");
`endif

endmodule

@@ hw/rtl/sgc_back.sv @@
// Back end: walks the queued glyph and issues one cell per cycle while the output is not stalled.
module sgc_back #(
  parameter int COORD_BITS = sgc_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                ld_valid,
  output logic                                ld_ready,
  input  logic [COORD_BITS-1:0]               ld_x,
  input  logic [COORD_BITS-1:0]               ld_y,
  input  sgc_pkg::sgc_cells_t                 ld_cells,
  input  logic [sgc_pkg::SCALE_BITS-1:0]      cell_scale,
  input  sgc_pkg::sgc_colour_t                colour,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [COORD_BITS-1:0]               out_cell_x,
  output logic [COORD_BITS-1:0]               out_cell_y,
  output logic [sgc_pkg::COLOUR_BITS-1:0]     out_fill_red,
  output logic [sgc_pkg::COLOUR_BITS-1:0]     out_fill_green,
  output logic [sgc_pkg::COLOUR_BITS-1:0]     out_fill_blue,
  output logic                                out_last_cell
);
  import sgc_pkg::*;

  logic                  busy_r, busy_nxt;
  glyph_t                rem_r, rem_nxt;
  glyph_t                lit_r, lit_nxt;
  logic [COORD_BITS-1:0] base_x_r, base_x_nxt;
  logic [COORD_BITS-1:0] base_y_r, base_y_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] cell_x_r, cell_y_r;
  sgc_colour_t           fill_r;
  logic                  last_r;

  glyph_t                low, rem_left;
  cell_idx_t             idx;
  logic [1:0]            col;
  logic [2:0]            row;
  logic [9:0]            x_off;
  logic [10:0]           y_off;
  logic [31:0]           x_ext, y_ext;
  logic                  can_emit, fire, final_cell, is_lit;

  // Lowest bit still to draw
  assign low      = rem_r & (~rem_r + 1'b1);
  assign rem_left = rem_r & ~low;

  always_comb begin
    idx = '0;
    for (int k = GLYPH_BITS - 1; k >= 0; k--) begin
      if (rem_r[k]) begin
        idx = CELL_IDX_BITS'(k);
      end
    end
  end

  assign col   = CELL_COL[idx];
  assign row   = CELL_ROW[idx];
  assign x_off = ({2'd0, cell_scale} & {10{col[0]}})
               + (({2'd0, cell_scale} << 1) & {10{col[1]}});
  assign y_off = 11'(row) * {3'd0, cell_scale};
  assign x_ext = 32'(x_off);
  assign y_ext = 32'(y_off);

  assign is_lit     = (low & lit_r) != '0;
  assign can_emit   = !out_valid_r || out_ready;
  assign fire       = busy_r && can_emit;
  assign final_cell = (rem_left == '0);
  assign ld_ready   = !busy_r || (fire && final_cell);

  always_comb begin
    busy_nxt      = busy_r;
    rem_nxt       = rem_r;
    lit_nxt       = lit_r;
    base_x_nxt    = base_x_r;
    base_y_nxt    = base_y_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fire) begin
      out_valid_nxt = 1'b1;
      rem_nxt       = rem_left;
      if (final_cell) begin
        busy_nxt = 1'b0;
      end
    end
    if (ld_valid && ld_ready) begin
      busy_nxt   = 1'b1;
      rem_nxt    = ld_cells.emit;
      lit_nxt    = ld_cells.lit;
      base_x_nxt = ld_x;
      base_y_nxt = ld_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    lit_r    <= lit_nxt;
    base_x_r <= base_x_nxt;
    base_y_r <= base_y_nxt;
    if (fire) begin
      cell_x_r <= base_x_r + x_ext[COORD_BITS-1:0];
      cell_y_r <= base_y_r + y_ext[COORD_BITS-1:0];
      fill_r   <= is_lit ? colour : '0;
      last_r   <= final_cell;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_x     = cell_x_r;
  assign out_cell_y     = cell_y_r;
  assign out_fill_red   = fill_r.red;
  assign out_fill_green = fill_r.green;
  assign out_fill_blue  = fill_r.blue;
  assign out_last_cell  = last_r;

`ifndef SYNTH
  a_busy_has_cells: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r != '0)
    else $error("walker busy with no cells left");

  a_load_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ld_valid && ld_ready |-> ld_cells.emit != '0)
    else $error("empty glyph reached the back end");

  a_walk_continues: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !final_cell |=> busy_r && out_valid_r && !out_last_cell)
    else $error("glyph walk stopped early");
`endif

endmodule

@@ hw/rtl/scaled_glyph_cell_generator.sv @@
// Top level of the scaled glyph cell generator: configuration registers and wiring.
// Each character request is looked up in a 3x5 glyph font (digits, capitals, space,
// - + : = . !, a box for anything else) and turned into one output request per drawn
// cell, giving the cell's top-left corner and fill colour; last_cell marks the final
// cell of a character. Carriage return, line feed and characters with nothing to draw
// (scale 0, or unlit cells without background clearing) move the cursor and give no
// output. Throughput: the front end takes a character every cycle while its two-entry
// glyph queue has room; the back end issues one cell per cycle while the output is not
// stalled, and a character gives one cell for each drawn cell, 1 to 15. An accepted
// character passes through the queue, the back end's walker and its output register.
// Output is registered, so a stalled output does not block acceptance until the queue
// fills. Coordinates wrap at COORD_BITS bits. Configuration writes are taken
// at any time (cfg_ready is always high) but must only be issued while the block is idle.
module scaled_glyph_cell_generator #(
  parameter int COORD_BITS = sgc_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_char_code,
  input  logic                                in_first_char,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [COORD_BITS-1:0]               out_cell_x,
  output logic [COORD_BITS-1:0]               out_cell_y,
  output logic [sgc_pkg::COLOUR_BITS-1:0]     out_fill_red,
  output logic [sgc_pkg::COLOUR_BITS-1:0]     out_fill_green,
  output logic [sgc_pkg::COLOUR_BITS-1:0]     out_fill_blue,
  output logic                                out_last_cell,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sgc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [sgc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import sgc_pkg::*;

  localparam int ENTRY_BITS = 2 * COORD_BITS + $bits(sgc_cells_t);

  // Configuration registers
  logic [COORD_BITS-1:0] origin_x_r, origin_y_r;
  logic [SCALE_BITS-1:0] scale_r;
  sgc_colour_t           colour_r;
  logic                  clear_bg_r;
  logic                  cfg_wr;

  // Front to queue
  logic                  push_valid, push_ready;
  logic [COORD_BITS-1:0] push_x, push_y;
  sgc_cells_t            push_cells;

  // Queue to back
  logic                  ld_valid, ld_ready;
  logic [COORD_BITS-1:0] ld_x, ld_y;
  sgc_cells_t            ld_cells;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Unlisted indexes are dropped; upper data bits beyond a register are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      scale_r        <= SCALE_BITS'(1);
      colour_r.red   <= '1;
      colour_r.green <= '1;
      colour_r.blue  <= '1;
      clear_bg_r     <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_ORIGIN_X:   origin_x_r     <= cfg_data[COORD_BITS-1:0];
        REG_ORIGIN_Y:   origin_y_r     <= cfg_data[COORD_BITS-1:0];
        REG_CELL_SCALE: scale_r        <= cfg_data[SCALE_BITS-1:0];
        REG_COLOR_R:    colour_r.red   <= cfg_data[COLOUR_BITS-1:0];
        REG_COLOR_G:    colour_r.green <= cfg_data[COLOUR_BITS-1:0];
        REG_COLOR_B:    colour_r.blue  <= cfg_data[COLOUR_BITS-1:0];
        REG_CLEAR_BG:   clear_bg_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sgc_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .in_first_char    (in_first_char),
    .origin_x         (origin_x_r),
    .origin_y         (origin_y_r),
    .cell_scale       (scale_r),
    .clear_background (clear_bg_r),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_x           (push_x),
    .push_y           (push_y),
    .push_cells       (push_cells)
  );

  sgc_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_x, push_y, push_cells}),
    .pop_valid  (ld_valid),
    .pop_ready  (ld_ready),
    .pop_data   ({ld_x, ld_y, ld_cells})
  );

  sgc_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .ld_valid       (ld_valid),
    .ld_ready       (ld_ready),
    .ld_x           (ld_x),
    .ld_y           (ld_y),
    .ld_cells       (ld_cells),
    .cell_scale     (scale_r),
    .colour         (colour_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_x     (out_cell_x),
    .out_cell_y     (out_cell_y),
    .out_fill_red   (out_fill_red),
    .out_fill_green (out_fill_green),
    .out_fill_blue  (out_fill_blue),
    .out_last_cell  (out_last_cell)
  );

endmodule
